// ===== rtl/core/grq_pkg.sv =====
// ----------------------------------------------------------------------------
// grq_pkg
// Shared types and constants for the gossip relay queue: queue sizing, result
// kinds, relay outcomes, register indexes and the jitter remainder constants.
// ----------------------------------------------------------------------------
package grq_pkg;

  // relay queue sizing
  localparam int QDEPTH = 8;
  localparam int QW     = $clog2(QDEPTH);
  localparam int CNTW   = $clog2(QDEPTH + 1);

  // per-id last relayed clock table
  localparam int NUM_ELEM = 64;
  localparam int LRC_AW   = $clog2(NUM_ELEM);

  // jitter remainder: one hex digit per step, x mod 50 via reciprocal 41 / 2^11
  localparam int             JIT_MOD    = 50;
  localparam int             JIT_REM_W  = $clog2(JIT_MOD);
  localparam int             JIT_DIGITS = 8;
  localparam int             JIT_CNT_W  = $clog2(JIT_DIGITS + 1);
  localparam int             JIT_X_W    = JIT_REM_W + 4;
  localparam int             JIT_PROD_W = JIT_X_W + 6;
  localparam int             JIT_SHIFT  = 11;
  localparam logic [5:0]     JIT_RECIP  = 6'd41;

  // command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_VERSION    = 3'd1;
  localparam logic [2:0] KIND_OWN_ID     = 3'd2;
  localparam logic [2:0] KIND_RELAYED    = 3'd3;
  localparam logic [2:0] KIND_FLUSH_IDLE = 3'd4;

  // relay outcomes
  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_APPEND  = 2'd1;
  localparam logic [1:0] OUT_EVICT   = 2'd2;
  localparam logic [1:0] OUT_DROPPED = 2'd3;

  // register indexes
  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_VERSION   = 2'd1;
  localparam logic [1:0] REG_COUNT_OWN = 2'd2;

  // register reset values
  localparam logic [7:0] OWN_ID_RST    = 8'd0;
  localparam logic [7:0] VERSION_RST   = 8'd5;
  localparam logic       COUNT_OWN_RST = 1'b1;

  // queue entry header
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] clock;
    logic [3:0]  hops;
    logic [3:0]  qos;
  } qhdr_t;

  localparam int HDR_W = $bits(qhdr_t);

  // one result transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  outcome;
    logic [7:0]  id;
    logic [31:0] clock;
    logic [3:0]  hops;
    logic [3:0]  qos;
    logic [31:0] payload;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/grq_ram.sv =====
// ----------------------------------------------------------------------------
// grq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/grq_jitter.sv =====
// ----------------------------------------------------------------------------
// grq_jitter
// Remainder of a 32-bit random word by 50, one hex digit per cycle, using a
// small reciprocal multiply for each digit step.
// ----------------------------------------------------------------------------
module grq_jitter
  import grq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          operand,
  output logic                 busy,
  output logic [JIT_REM_W-1:0] rem
);

  logic [JIT_CNT_W-1:0]  cnt;
  logic [31:0]           sh;
  logic [JIT_X_W-1:0]    x;
  logic [JIT_PROD_W-1:0] prod;
  logic [3:0]            quo;
  logic [JIT_X_W-1:0]    r_step;

  // digit step: x = rem*16 + digit, quotient by reciprocal, remainder by subtract
  assign x      = {rem, sh[31:28]};
  assign prod   = JIT_PROD_W'(x) * JIT_PROD_W'(JIT_RECIP);
  assign quo    = 4'(prod >> JIT_SHIFT);
  assign r_step = x - JIT_X_W'(quo) * JIT_X_W'(JIT_MOD);

  assign busy = (cnt != '0);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= JIT_CNT_W'(JIT_DIGITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // operand shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= operand;
      rem <= '0;
    end else if (busy) begin
      sh  <= sh << 4;
      rem <= JIT_REM_W'(r_step);
    end
  end

endmodule

// ===== rtl/core/gossip_relay_queue_qos_evict.sv =====
// A frame is filtered in the look state: a dropped or non-queued frame gives its
// result from there, an append waits for the 8 jitter remainder digit steps, and a
// frame into a full queue runs the 8-entry QoS scan first. A flush gives one result
// per cycle, an idle flush a single result. One command at a time: the next start is
// taken at the edge that takes the last result; the receiver cannot stall.
// Reset clears control state and the per-id valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
// gossip_relay_queue_qos_evict
// Gossip frame filter and relay queue with QoS eviction and jittered flush.
// ----------------------------------------------------------------------------
module gossip_relay_queue_qos_evict
  import grq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  frame_id,
  input  logic [7:0]  frame_version,
  input  logic [31:0] frame_clock,
  input  logic [3:0]  frame_hops,
  input  logic [3:0]  frame_qos,
  input  logic [31:0] payload_ref,
  input  logic [31:0] now_ms,
  input  logic [31:0] jitter_random,
  // results
  output logic        done,
  output logic [2:0]  kind,
  output logic [1:0]  relay_outcome,
  output logic [7:0]  out_id,
  output logic [31:0] out_clock,
  output logic [3:0]  out_hops,
  output logic [3:0]  out_qos,
  output logic [31:0] out_payload_ref,
  output logic [31:0] own_id_total,
  output logic        last
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_EVICT  = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;

  logic [2:0]  state, state_next;

  // configuration registers
  logic [7:0]  own_id;
  logic [7:0]  exp_version;
  logic        count_own;
  logic        cfg_we;

  // latched frame
  logic [7:0]  f_id;
  logic [7:0]  f_version;
  logic [31:0] f_clock;
  logic [3:0]  f_hops;
  logic [3:0]  f_qos;
  logic [31:0] f_payload;
  logic [31:0] f_now;

  // block state
  logic [CNTW-1:0]     queue_count, queue_count_next;
  logic [31:0]         flush_time, flush_time_next;
  logic [31:0]         own_id_counter, own_id_counter_next;
  logic [QW-1:0]       scan_idx, scan_idx_next;
  logic [QW-1:0]       worst_idx, worst_idx_next;
  logic [3:0]          best_qos, best_qos_next;
  logic [NUM_ELEM-1:0] lrc_valid;

  // result register
  res_t res, res_next;
  logic done_next;

  // memory ports
  logic              lrc_we;
  logic [31:0]       lrc_rdata;
  logic [31:0]       lrc_stored;
  logic              q_we;
  logic [QW-1:0]     q_waddr;
  logic [QW-1:0]     q_raddr;
  qhdr_t             q_hdr_w, q_hdr_r;
  logic [31:0]       q_pay_r;

  // jitter unit
  logic                 jit_start;
  logic                 jit_busy;
  logic [JIT_REM_W-1:0] jit_rem;

  logic accept;
  logic qualify;
  logic flush_empty;
  logic flush_last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_OWN_ID:    prdata = {24'd0, own_id};
      REG_VERSION:   prdata = {24'd0, exp_version};
      REG_COUNT_OWN: prdata = {31'd0, count_own};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id      <= OWN_ID_RST;
      exp_version <= VERSION_RST;
      count_own   <= COUNT_OWN_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_OWN_ID:    own_id      <= pwdata[7:0];
        REG_VERSION:   exp_version <= pwdata[7:0];
        REG_COUNT_OWN: count_own   <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // memories
  grq_ram #(.WIDTH(32), .DEPTH(NUM_ELEM)) u_lrc_ram (
    .clk   (clk),
    .we    (lrc_we),
    .waddr (f_id[LRC_AW-1:0]),
    .wdata (f_clock),
    .raddr (frame_id[LRC_AW-1:0]),
    .rdata (lrc_rdata)
  );

  grq_ram #(.WIDTH(HDR_W), .DEPTH(QDEPTH)) u_qhdr_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_hdr_w),
    .raddr (q_raddr),
    .rdata (q_hdr_r)
  );

  grq_ram #(.WIDTH(32), .DEPTH(QDEPTH)) u_qpay_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (f_payload),
    .raddr (q_raddr),
    .rdata (q_pay_r)
  );

  grq_jitter u_jitter (
    .clk     (clk),
    .rst     (rst),
    .start   (jit_start),
    .operand (jitter_random),
    .busy    (jit_busy),
    .rem     (jit_rem)
  );

  // relay eligibility of the latched frame
  assign lrc_stored = lrc_valid[f_id[LRC_AW-1:0]] ? lrc_rdata : 32'd0;
  assign qualify    = (f_hops != 4'd0) && ({1'b0, f_id} < 9'(NUM_ELEM)) &&
                      (f_clock > lrc_stored);
  assign q_hdr_w    = '{id: f_id, clock: f_clock, hops: f_hops - 4'd1, qos: f_qos};

  assign flush_empty = (queue_count == '0) || (now_ms < flush_time);
  assign flush_last  = (CNTW'(scan_idx) + 1'b1 == queue_count);

  // queue read address runs one entry ahead of the scan or flush index
  assign q_raddr = (state == ST_SCAN || state == ST_FLUSH) ? scan_idx + 1'b1 : '0;

  // sequencer
  always_comb begin
    state_next          = state;
    queue_count_next    = queue_count;
    flush_time_next     = flush_time;
    own_id_counter_next = own_id_counter;
    scan_idx_next       = scan_idx;
    worst_idx_next      = worst_idx;
    best_qos_next       = best_qos;
    res_next            = res;
    done_next           = 1'b0;
    lrc_we              = 1'b0;
    q_we                = 1'b0;
    q_waddr             = queue_count[QW-1:0];
    jit_start           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_FLUSH) begin
            if (flush_empty) begin
              res_next      = '0;
              res_next.kind = KIND_FLUSH_IDLE;
              res_next.last = 1'b1;
              done_next     = 1'b1;
            end else begin
              scan_idx_next = '0;
              state_next    = ST_FLUSH;
            end
          end else begin
            jit_start  = 1'b1;
            state_next = ST_LOOK;
          end
        end
      end

      // filter the frame against version, own id and the last relayed clock
      ST_LOOK: begin
        if (f_version != exp_version) begin
          res_next      = '0;
          res_next.kind = KIND_VERSION;
          res_next.last = 1'b1;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end else if (f_id == own_id) begin
          if (count_own) begin
            own_id_counter_next = own_id_counter + 32'd1;
          end
          res_next      = '0;
          res_next.kind = KIND_OWN_ID;
          res_next.last = 1'b1;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end else if (qualify) begin
          lrc_we = 1'b1;
          if (queue_count < CNTW'(QDEPTH)) begin
            state_next = ST_APPEND;
          end else begin
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end
        end else begin
          res_next   = '{kind: KIND_ACCEPTED, outcome: OUT_NONE, id: f_id,
                         clock: f_clock, hops: f_hops, qos: f_qos,
                         payload: f_payload, last: 1'b1};
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      // append once the jitter remainder is ready
      ST_APPEND: begin
        if (!jit_busy) begin
          q_we    = 1'b1;
          q_waddr = queue_count[QW-1:0];
          if (queue_count == '0) begin
            flush_time_next = f_now + 32'(jit_rem);
          end
          queue_count_next = queue_count + 1'b1;
          res_next   = '{kind: KIND_ACCEPTED, outcome: OUT_APPEND, id: f_id,
                         clock: f_clock, hops: f_hops, qos: f_qos,
                         payload: f_payload, last: 1'b1};
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      // find the first lowest-qos entry
      ST_SCAN: begin
        if (scan_idx == '0 || q_hdr_r.qos < best_qos) begin
          best_qos_next  = q_hdr_r.qos;
          worst_idx_next = scan_idx;
        end
        if (scan_idx == QW'(QDEPTH - 1)) begin
          state_next = ST_EVICT;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      // evict only for a strictly higher qos
      ST_EVICT: begin
        res_next = '{kind: KIND_ACCEPTED, outcome: OUT_DROPPED, id: f_id,
                     clock: f_clock, hops: f_hops, qos: f_qos,
                     payload: f_payload, last: 1'b1};
        if (f_qos > best_qos) begin
          q_we             = 1'b1;
          q_waddr          = worst_idx;
          res_next.outcome = OUT_EVICT;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      // emit queued entries in order
      ST_FLUSH: begin
        res_next  = '{kind: KIND_RELAYED, outcome: OUT_NONE, id: q_hdr_r.id,
                      clock: q_hdr_r.clock, hops: q_hdr_r.hops, qos: q_hdr_r.qos,
                      payload: q_pay_r, last: flush_last};
        done_next = 1'b1;
        if (flush_last) begin
          queue_count_next = '0;
          state_next       = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      queue_count    <= '0;
      flush_time     <= '0;
      own_id_counter <= '0;
      lrc_valid      <= '0;
      done           <= 1'b0;
    end else begin
      state          <= state_next;
      queue_count    <= queue_count_next;
      flush_time     <= flush_time_next;
      own_id_counter <= own_id_counter_next;
      done           <= done_next;
      if (lrc_we) begin
        lrc_valid[f_id[LRC_AW-1:0]] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      f_id      <= frame_id;
      f_version <= frame_version;
      f_clock   <= frame_clock;
      f_hops    <= frame_hops;
      f_qos     <= frame_qos;
      f_payload <= payload_ref;
      f_now     <= now_ms;
    end
    scan_idx  <= scan_idx_next;
    worst_idx <= worst_idx_next;
    best_qos  <= best_qos_next;
    res       <= res_next;
  end

  // result ports
  assign kind            = res.kind;
  assign relay_outcome   = res.outcome;
  assign out_id          = res.id;
  assign out_clock       = res.clock;
  assign out_hops        = res.hops;
  assign out_qos         = res.qos;
  assign out_payload_ref = res.payload;
  assign last            = res.last;
  assign own_id_total    = own_id_counter;

`ifndef ASSERT_OFF
  // queue never holds more than its depth
  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CNTW'(QDEPTH))
    else $error("queue count above depth");

  // a flush burst continues until its last transaction
  ap_burst_run: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("flush burst broken before last");

  // an accepted frame always occupies the sequencer
  ap_frame_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_FRAME |=> busy)
    else $error("frame accepted without busy");

  // relay outcomes only accompany accepted frames
  ap_outcome_kind: assert property (@(posedge clk) disable iff (rst)
    done && relay_outcome != OUT_NONE |-> kind == KIND_ACCEPTED)
    else $error("relay outcome on wrong kind");

  // appended entries only when the queue had room
  ap_append_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPEND && !jit_busy |-> queue_count < CNTW'(QDEPTH))
    else $error("append into full queue");
`endif

endmodule
